/* design/ipft_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// IPv4 prefix filter package
// Shared constants, beat types and state encodings of the prefix filter table.
// ----------------------------------------------------------------------------
package ipft_pkg;

  localparam int unsigned MAX_RULES   = 16;
  localparam int unsigned ADDR_W      = 32;
  localparam int unsigned LEN_W       = 6;
  localparam int unsigned CNT_W       = $clog2(MAX_RULES + 1);
  localparam int unsigned IDX_W       = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1;

  // Command queue between the front and the back end; the depth is a power of two.
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QFILL_W     = $clog2(QUEUE_DEPTH + 1);

  // Longest prefix length that can match a rule.
  localparam logic [LEN_W-1:0] FULL_LEN = LEN_W'(ADDR_W);

  // APB register map.
  localparam int unsigned PADDR_W = 3;
  localparam int unsigned PDATA_W = 32;
  localparam logic [0:0]  REG_DEFAULT_REJECT = 1'b0;

  typedef enum logic {
    FUNC_LOOKUP = 1'b0,
    FUNC_APPEND = 1'b1
  } func_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_RESULT
  } eng_state_e;

  typedef struct packed {
    logic              func;
    logic [ADDR_W-1:0] addr_prefix;
    logic [LEN_W-1:0]  prefix_length;
    logic              rule_loose;
    logic              rule_reject;
  } in_t;

  typedef struct packed {
    logic verdict_reject;
    logic any_match;
    logic table_full;
  } out_t;

  // Classified command handed from the front end to the back end.
  typedef struct packed {
    func_e             kind;
    logic [ADDR_W-1:0] prefix;
    logic [LEN_W-1:0]  len;
    logic              loose;
    logic              reject;
    logic              len_ok;
  } cmd_t;

  typedef struct packed {
    logic [ADDR_W-1:0] prefix;
    logic [LEN_W-1:0]  len;
    logic              loose;
    logic              reject;
  } rule_t;

endpackage
`default_nettype wire

/* design/ipv4_prefix_filter_table.sv */
// Append: the accepted command goes to ST_RESULT, which loads the registered result.
// Lookup: ST_SCAN reads the stored rules through the table's single read port, one rule
// per cycle, into a registered compare, then ST_RESULT; no rule is read when the table is
// empty or the query is longer than 32 bits. A stalled result keeps the back end busy.
// A two-beat command queue lets new items be accepted while a scan is running.
// Reset clears rule count, queue, output valid and default_reject; the table is not cleared.
`default_nettype none
// ----------------------------------------------------------------------------
// IPv4 prefix filter table
// Ordered prefix rule table with append and lookup, plus an APB register port.
// ----------------------------------------------------------------------------
module ipv4_prefix_filter_table (
  input  wire                 logic clk_i,
  input  wire                 logic rst_ni,
  input  wire                 logic in_valid_i,
  output                      logic in_ready_o,
  input  wire  ipft_pkg::in_t       in_data_i,
  output                      logic out_valid_o,
  input  wire                 logic out_ready_i,
  output       ipft_pkg::out_t      out_data_o,
  input  wire                 logic psel,
  input  wire                 logic penable,
  input  wire                 logic pwrite,
  input  wire  logic [ipft_pkg::PADDR_W-1:0] paddr,
  input  wire  logic [ipft_pkg::PDATA_W-1:0] pwdata,
  output       logic [ipft_pkg::PDATA_W-1:0] prdata,
  output                      logic pready
);
  import ipft_pkg::*;

  logic default_reject_q;
  logic reg_sel;
  logic reg_wr;
  logic cmd_valid;
  logic cmd_ready;
  cmd_t cmd;

  assign pready  = 1'b1;
  assign reg_sel = (paddr[PADDR_W-1:2] == REG_DEFAULT_REJECT);
  assign reg_wr  = psel && penable && pwrite && pready && reg_sel;
  assign prdata  = reg_sel ? PDATA_W'(default_reject_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      default_reject_q <= 1'b0;
    end else if (reg_wr) begin
      default_reject_q <= pwdata[0];
    end
  end

  ipft_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .cmd_valid_o (cmd_valid),
    .cmd_ready_i (cmd_ready),
    .cmd_o       (cmd)
  );

  ipft_engine u_engine (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .default_reject_i (default_reject_q),
    .cmd_valid_i      (cmd_valid),
    .cmd_ready_o      (cmd_ready),
    .cmd_i            (cmd),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .out_data_o       (out_data_o)
  );

endmodule
`default_nettype wire

/* design/ipft_front.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Prefix filter front end
// Accepts input beats, classifies them and queues them for the back end.
// ----------------------------------------------------------------------------
module ipft_front (
  input  wire                logic clk_i,
  input  wire                logic rst_ni,
  input  wire                logic in_valid_i,
  output                     logic in_ready_o,
  input  wire  ipft_pkg::in_t      in_data_i,
  output                     logic cmd_valid_o,
  input  wire                logic cmd_ready_i,
  output       ipft_pkg::cmd_t     cmd_o
);
  import ipft_pkg::*;

  cmd_t               queue_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0]  rd_ptr_q, rd_ptr_d;
  logic [QFILL_W-1:0] fill_q, fill_d;
  cmd_t               cmd_new;
  logic               push;
  logic               pop;

  assign in_ready_o  = (fill_q != QFILL_W'(QUEUE_DEPTH));
  assign cmd_valid_o = (fill_q != '0);
  assign cmd_o       = queue_q[rd_ptr_q];

  assign push = in_valid_i && in_ready_o;
  assign pop  = cmd_valid_o && cmd_ready_i;

  always_comb begin
    cmd_new.kind   = func_e'(in_data_i.func);
    cmd_new.prefix = in_data_i.addr_prefix;
    cmd_new.len    = in_data_i.prefix_length;
    cmd_new.loose  = in_data_i.rule_loose;
    cmd_new.reject = in_data_i.rule_reject;
    // Lookups longer than a full address can never match any rule.
    cmd_new.len_ok = (in_data_i.prefix_length <= FULL_LEN);
  end

  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + QPTR_W'(1) : wr_ptr_q;
    rd_ptr_d = pop  ? rd_ptr_q + QPTR_W'(1) : rd_ptr_q;
    fill_d   = fill_q + QFILL_W'(push) - QFILL_W'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      queue_q[wr_ptr_q] <= cmd_new;
    end
  end

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= QFILL_W'(QUEUE_DEPTH))
    else $error("command queue overfilled");

  a_fill_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !pop) |=> (fill_q == $past(fill_q) + QFILL_W'(1)))
    else $error("command queue fill count lost a beat");

  a_ptr_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr_ptr_q - rd_ptr_q) == fill_q[QPTR_W-1:0])
    else $error("command queue pointers disagree with the fill count");
`endif

endmodule
`default_nettype wire

/* design/ipft_engine.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Prefix filter back end
// Holds the rule table, appends rules and scans it one rule per cycle.
// ----------------------------------------------------------------------------
module ipft_engine (
  input  wire                 logic clk_i,
  input  wire                 logic rst_ni,
  input  wire                 logic default_reject_i,
  input  wire                 logic cmd_valid_i,
  output                      logic cmd_ready_o,
  input  wire  ipft_pkg::cmd_t      cmd_i,
  output                      logic out_valid_o,
  input  wire                 logic out_ready_i,
  output       ipft_pkg::out_t      out_data_o
);
  import ipft_pkg::*;

  rule_t             mem_q [MAX_RULES];
  eng_state_e        state_q, state_d;
  logic [CNT_W-1:0]  count_q;
  logic [CNT_W-1:0]  idx_q;
  logic              cmp_vld_q;
  rule_t             rdata_q;
  cmd_t              qry_q;
  logic              verdict_q;
  logic              matched_q;
  logic              full_q;
  out_t              out_q;
  logic              out_valid_q;

  logic              take;
  logic              issue;
  logic              out_load;
  logic              has_room;
  logic              append_wr;
  logic              rule_hit;
  rule_t             new_rule;

  function automatic logic rule_match(rule_t r, cmd_t q);
    logic [ADDR_W-1:0] net_mask;
    net_mask = ~({ADDR_W{1'b1}} >> r.len);
    if (!q.len_ok) begin
      return 1'b0;
    end else if (!r.loose) begin
      return (r.prefix == q.prefix) && (r.len == q.len);
    end else begin
      // A loose rule must be no longer than the query and cover its network.
      return (r.len <= q.len) && (((r.prefix ^ q.prefix) & net_mask) == '0);
    end
  endfunction

  assign has_room  = (count_q < CNT_W'(MAX_RULES));
  assign take      = cmd_valid_i && cmd_ready_o;
  assign append_wr = take && (cmd_i.kind == FUNC_APPEND) && has_room;
  assign rule_hit  = cmp_vld_q && rule_match(rdata_q, qry_q);

  always_comb begin
    new_rule.prefix = cmd_i.prefix;
    new_rule.len    = cmd_i.len;
    new_rule.loose  = cmd_i.loose;
    new_rule.reject = cmd_i.reject;
  end

  // Control outputs of the sequencer.
  always_comb begin
    cmd_ready_o = 1'b0;
    issue       = 1'b0;
    out_load    = 1'b0;
    case (state_q)
      ST_IDLE: begin
        cmd_ready_o = 1'b1;
      end
      ST_SCAN: begin
        issue = qry_q.len_ok && (idx_q < count_q);
      end
      ST_RESULT: begin
        out_load = !out_valid_q || out_ready_i;
      end
      default: begin
      end
    endcase
  end

  // Next state of the sequencer.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i) begin
          state_d = (cmd_i.kind == FUNC_APPEND) ? ST_RESULT : ST_SCAN;
        end
      end
      ST_SCAN: begin
        // Leave once every stored rule has been read and compared, or at once for a query longer than a full address.
        if (!issue && !cmp_vld_q) begin
          state_d = ST_RESULT;
        end
      end
      ST_RESULT: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      idx_q       <= '0;
      cmp_vld_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cmp_vld_q <= issue;
      if (append_wr) begin
        count_q <= count_q + CNT_W'(1);
      end
      if (take) begin
        idx_q <= '0;
      end else if (issue) begin
        idx_q <= idx_q + CNT_W'(1);
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Rule table: one write port for appends, one registered read port for scans.
  always_ff @(posedge clk_i) begin
    if (append_wr) begin
      mem_q[count_q[IDX_W-1:0]] <= new_rule;
    end
    if (issue) begin
      rdata_q <= mem_q[idx_q[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      qry_q     <= cmd_i;
      verdict_q <= (cmd_i.kind == FUNC_LOOKUP) ? default_reject_i : 1'b0;
      matched_q <= 1'b0;
      full_q    <= (cmd_i.kind == FUNC_APPEND) && !has_room;
    end else if (rule_hit) begin
      // Later rules override earlier ones, so the last hit wins.
      verdict_q <= rdata_q.reject;
      matched_q <= 1'b1;
    end
    if (out_load) begin
      out_q.verdict_reject <= verdict_q;
      out_q.any_match      <= matched_q;
      out_q.table_full     <= full_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(MAX_RULES))
    else $error("rule count exceeds table depth");

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q != $past(count_q)) |-> (count_q == $past(count_q) + CNT_W'(1)))
    else $error("rule count moved by more than one");

  a_cmp_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmp_vld_q |-> (state_q == ST_SCAN))
    else $error("rule compare outside of a scan");

  a_result_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(out_q.table_full && (out_q.any_match || out_q.verdict_reject)))
    else $error("full flag mixed with a lookup verdict");
`endif

endmodule
`default_nettype wire

/* test/ipv4_prefix_filter_table_check.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IPv4 prefix filter table checker
// Watches the command, result and register channels of the filter table. It
// keeps its own copy of the rule list and the default verdict, works out the
// result of every accepted command, and compares each result beat in order.
// ----------------------------------------------------------------------------
module ipv4_prefix_filter_table_check (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  input  logic                         in_ready_i,
  input  ipft_pkg::in_t                in_data_i,
  input  logic                         out_valid_i,
  input  logic                         out_ready_i,
  input  ipft_pkg::out_t               out_data_i,
  input  logic                         psel_i,
  input  logic                         penable_i,
  input  logic                         pwrite_i,
  input  logic [ipft_pkg::PADDR_W-1:0] paddr_i,
  input  logic [ipft_pkg::PDATA_W-1:0] pwdata_i,
  input  logic [ipft_pkg::PDATA_W-1:0] prdata_i,
  input  logic                         pready_i,
  output int                           fail_count_o,
  output int                           pending_o
);
  import ipft_pkg::*;

  localparam logic [PADDR_W-1:0] DEFAULT_REJECT_ADDR = PADDR_W'(4 * REG_DEFAULT_REJECT);

  rule_t rule_table [MAX_RULES];
  int    rule_total;
  logic  reject_by_default;
  out_t  verdict_q [$];
  out_t  want;

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    fail_count_o++;
  endtask

  function automatic logic [ADDR_W-1:0] network_mask(input logic [LEN_W-1:0] len);
    if (len == '0) begin
      return '0;
    end
    if (len >= FULL_LEN) begin
      return '1;
    end
    return {ADDR_W{1'b1}} << (ADDR_W - len);
  endfunction

  function automatic bit rule_hits(input rule_t r, input in_t query);
    if (query.prefix_length > FULL_LEN) begin
      return 1'b0;
    end
    if (!r.loose) begin
      return r.prefix == query.addr_prefix && r.len == query.prefix_length;
    end
    // A loose rule covers the query only if its network is no longer than it.
    if (r.len > query.prefix_length) begin
      return 1'b0;
    end
    return ((r.prefix ^ query.addr_prefix) & network_mask(r.len)) == '0;
  endfunction

  function automatic out_t apply_command(input in_t cmd);
    out_t res;
    res = '0;
    if (cmd.func == FUNC_APPEND) begin
      if (rule_total < MAX_RULES) begin
        rule_table[rule_total] = '{prefix: cmd.addr_prefix, len: cmd.prefix_length,
                                   loose: cmd.rule_loose, reject: cmd.rule_reject};
        rule_total++;
      end else begin
        res.table_full = 1'b1;
      end
    end else begin
      // The last matching rule in table order decides.
      res.verdict_reject = reject_by_default;
      for (int i = 0; i < rule_total; i++) begin
        if (rule_hits(rule_table[i], cmd)) begin
          res.verdict_reject = rule_table[i].reject;
          res.any_match      = 1'b1;
        end
      end
    end
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      verdict_q.delete();
      rule_total        = 0;
      reject_by_default = 1'b0;
      pending_o         = 0;
      fail_count_o      = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (verdict_q.size() == 0) begin
          report_mismatch($sformatf("result beat %b with nothing expected", out_data_i));
        end else begin
          want = verdict_q.pop_front();
          if (out_data_i.verdict_reject !== want.verdict_reject) begin
            report_mismatch($sformatf("verdict_reject %b, expected %b",
                                      out_data_i.verdict_reject, want.verdict_reject));
          end
          if (out_data_i.any_match !== want.any_match) begin
            report_mismatch($sformatf("any_match %b, expected %b",
                                      out_data_i.any_match, want.any_match));
          end
          if (out_data_i.table_full !== want.table_full) begin
            report_mismatch($sformatf("table_full %b, expected %b",
                                      out_data_i.table_full, want.table_full));
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        verdict_q.insert(verdict_q.size(), apply_command(in_data_i));
      end
      if (psel_i && penable_i && pready_i && paddr_i == DEFAULT_REJECT_ADDR) begin
        if (pwrite_i) begin
          reject_by_default = pwdata_i[0];
        end else if (prdata_i !== PDATA_W'(reject_by_default)) begin
          report_mismatch($sformatf("default_reject read %h, expected %h",
                                    prdata_i, PDATA_W'(reject_by_default)));
        end
      end
      pending_o = verdict_q.size();
    end
  end

endmodule

/* test/ipv4_prefix_filter_table_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IPv4 prefix filter table testbench
// Drives directed and random append and lookup commands with random gaps and
// result stalls, switches the default verdict between phases, and reports the
// outcome of the checker that runs beside the filter table.
// ----------------------------------------------------------------------------
module ipv4_prefix_filter_table_test;
  import ipft_pkg::*;

  localparam logic [PADDR_W-1:0] DEFAULT_REJECT_ADDR = PADDR_W'(4 * REG_DEFAULT_REJECT);
  localparam int SETTLE_CYCLES  = 32;
  localparam int RX_HOLD_CYCLES = 200;
  localparam int PHASE_ITEMS    = 250;

  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               in_valid_i  = 1'b0;
  logic               in_ready_o;
  in_t                in_data_i   = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  out_t               out_data_o;
  logic               psel        = 1'b0;
  logic               penable     = 1'b0;
  logic               pwrite      = 1'b0;
  logic [PADDR_W-1:0] paddr       = '0;
  logic [PDATA_W-1:0] pwdata      = '0;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  int fail_count;
  int pending;

  bit idle_on     = 1'b0;
  bit rx_hold_req = 1'b0;

  // Rules appended so far, used to aim lookups at stored networks.
  logic [ADDR_W-1:0] known_prefix [$];
  logic [LEN_W-1:0]  known_len [$];

  always #5 clk_i = ~clk_i;

  ipv4_prefix_filter_table i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  ipv4_prefix_filter_table_check i_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_i   (in_ready_o),
    .in_data_i    (in_data_i),
    .out_valid_i  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_data_i   (out_data_o),
    .psel_i       (psel),
    .penable_i    (penable),
    .pwrite_i     (pwrite),
    .paddr_i      (paddr),
    .pwdata_i     (pwdata),
    .prdata_i     (prdata),
    .pready_i     (pready),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  function automatic in_t beat(input func_e func, input logic [ADDR_W-1:0] prefix,
                               input logic [LEN_W-1:0] len, input bit loose,
                               input bit reject);
    in_t b;
    b.func          = func;
    b.addr_prefix   = prefix;
    b.prefix_length = len;
    b.rule_loose    = loose;
    b.rule_reject   = reject;
    return b;
  endfunction

  function automatic in_t random_beat();
    in_t               b;
    int                k;
    logic [ADDR_W-1:0] base;
    logic [LEN_W-1:0]  blen;
    b             = '0;
    b.rule_loose  = 1'($urandom_range(0, 1));
    b.rule_reject = 1'($urandom_range(0, 1));
    if ($urandom_range(0, 99) < 15) begin
      b.func          = FUNC_APPEND;
      b.addr_prefix   = $urandom;
      b.prefix_length = ($urandom_range(0, 4) == 0) ? LEN_W'($urandom_range(33, 63))
                                                    : LEN_W'($urandom_range(0, ADDR_W));
      // Nest some rules inside earlier ones so that several rules overlap.
      if (known_prefix.size() != 0 && $urandom_range(0, 1) == 1) begin
        k             = $urandom_range(0, known_prefix.size() - 1);
        b.addr_prefix = known_prefix[k] ^ ($urandom >> known_len[k]);
      end
    end else begin
      b.func = FUNC_LOOKUP;
      if (known_prefix.size() == 0 || $urandom_range(0, 3) == 0) begin
        b.addr_prefix   = $urandom;
        b.prefix_length = LEN_W'($urandom_range(0, 63));
      end else begin
        k    = $urandom_range(0, known_prefix.size() - 1);
        base = known_prefix[k];
        blen = known_len[k];
        case ($urandom_range(0, 2))
          0: begin
            b.addr_prefix   = base;
            b.prefix_length = blen;
          end
          1: begin
            // Same network, longer or equal length, random host bits.
            b.prefix_length = (blen > FULL_LEN) ? blen
                                                : LEN_W'($urandom_range(blen, ADDR_W));
            b.addr_prefix   = base ^ ($urandom >> blen);
          end
          default: begin
            b.addr_prefix   = base ^ (32'h1 << $urandom_range(0, 31));
            b.prefix_length = blen + LEN_W'($urandom_range(0, 2)) - LEN_W'(1);
          end
        endcase
      end
    end
    return b;
  endfunction

  // Called right after a rising edge; returns at the edge that takes the beat,
  // with valid left high so that a following beat can go out without a gap.
  task automatic send_beat(input in_t b);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
    if (b.func == FUNC_APPEND && known_prefix.size() < MAX_RULES) begin
      known_prefix.insert(known_prefix.size(), b.addr_prefix);
      known_len.insert(known_len.size(), b.prefix_length);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= b;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  task automatic run_random(input int count);
    repeat (count) send_beat(random_beat());
  endtask

  // Stops the command stream and waits until every result has come back.
  task automatic settle();
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
    @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic cfg_access(input bit write, input logic [PDATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= write;
    paddr   <= DEFAULT_REJECT_ADDR;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic write_default_reject(input bit value);
    settle();
    cfg_access(1'b1, PDATA_W'(value));
    cfg_access(1'b0, '0);
    @(posedge clk_i);
  endtask

  // Result side: random stalls, plus one long hold that backs up the table.
  initial begin : receiver
    int stall_left;
    stall_left = 0;
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        out_ready_i <= 1'b0;
        repeat (RX_HOLD_CYCLES) @(posedge clk_i);
        stall_left = 0;
      end else if (!idle_on) begin
        out_ready_i <= 1'b1;
      end else if (stall_left > 0) begin
        out_ready_i <= 1'b0;
        stall_left--;
      end else if ($urandom_range(0, 5) == 0) begin
        out_ready_i <= 1'b0;
        stall_left = $urandom_range(1, 8) - 1;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  initial begin : stimulus
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    idle_on = 1'b1;

    // Empty table: the default verdict answers everything.
    send_beat(beat(FUNC_LOOKUP, 32'h0000_0000, 6'd0, 1'b0, 1'b0));
    send_beat(beat(FUNC_LOOKUP, 32'hFFFF_FFFF, 6'd63, 1'b1, 1'b1));
    write_default_reject(1'b1);
    send_beat(beat(FUNC_LOOKUP, 32'h1234_5678, 6'd24, 1'b0, 1'b0));

    // Strict rule: exact prefix and length, prefixes compared unmasked.
    send_beat(beat(FUNC_APPEND, 32'hC0A8_0100, 6'd24, 1'b0, 1'b0));
    send_beat(beat(FUNC_LOOKUP, 32'hC0A8_0100, 6'd24, 1'b0, 1'b0));
    send_beat(beat(FUNC_LOOKUP, 32'hC0A8_0101, 6'd24, 1'b0, 1'b0));
    send_beat(beat(FUNC_LOOKUP, 32'hC0A8_0100, 6'd25, 1'b0, 1'b0));

    // Loose rule: containment, rule longer than query, query above 32 bits.
    send_beat(beat(FUNC_APPEND, 32'h0A00_0000, 6'd8, 1'b1, 1'b1));
    send_beat(beat(FUNC_LOOKUP, 32'h0A12_3456, 6'd16, 1'b0, 1'b0));
    send_beat(beat(FUNC_LOOKUP, 32'h0A00_0000, 6'd8, 1'b0, 1'b0));
    send_beat(beat(FUNC_LOOKUP, 32'h0A00_0000, 6'd7, 1'b0, 1'b0));
    send_beat(beat(FUNC_LOOKUP, 32'h0A00_0000, 6'd33, 1'b0, 1'b0));

    // Catch-all rule; the last of several matching rules wins.
    send_beat(beat(FUNC_APPEND, 32'h0000_0000, 6'd0, 1'b1, 1'b0));
    send_beat(beat(FUNC_LOOKUP, 32'hFFFF_FFFF, 6'd32, 1'b0, 1'b0));
    send_beat(beat(FUNC_LOOKUP, 32'h0A00_0001, 6'd32, 1'b0, 1'b0));

    // A rule longer than 32 bits is stored but never matches.
    send_beat(beat(FUNC_APPEND, 32'hFFFF_FFFF, 6'd63, 1'b1, 1'b1));
    send_beat(beat(FUNC_LOOKUP, 32'hFFFF_FFFF, 6'd32, 1'b0, 1'b0));
    send_beat(beat(FUNC_APPEND, 32'hFFFF_FFFF, 6'd32, 1'b0, 1'b1));
    send_beat(beat(FUNC_LOOKUP, 32'hFFFF_FFFF, 6'd32, 1'b0, 1'b0));

    // Random phases; the table fills early and later appends come back full.
    write_default_reject(1'b0);
    run_random(PHASE_ITEMS);
    write_default_reject(1'b1);
    rx_hold_req = 1'b1;
    run_random(PHASE_ITEMS);
    write_default_reject(1'b0);
    idle_on = 1'b0;
    run_random(PHASE_ITEMS);
    settle();

    if (fail_count == 0) begin
      $display("** ipv4_prefix_filter_table: PASSED **");
    end else begin
      $display("** ipv4_prefix_filter_table: FAILED **");
    end
    $finish;
  end

  initial begin : watchdog
    #3_000_000;
    $display("** ipv4_prefix_filter_table: FAILED **");
    $finish;
  end

endmodule
